>>> rtl/fpda_pkg.sv
// ----------------------------------------------------------------------------
// fpda_pkg
// Shared types and constants of the scaled decimal fixed-point ALU.
// ----------------------------------------------------------------------------
package fpda_pkg;

    // Decimal scale of a price: the stored integer p stands for p / SCALE.
    localparam logic [63:0] SCALE      = 64'd1000000000;
    localparam logic [63:0] SCALE_HALF = SCALE >> 1;

    // Restoring division steps: one quotient bit per cell over a 128-bit dividend.
    localparam int DIV_STEPS = 128;

    typedef enum logic [3:0] {
        KIND_ADD     = 4'd0,
        KIND_SUB     = 4'd1,
        KIND_MUL     = 4'd2,
        KIND_DIV     = 4'd3,
        KIND_INTDIV  = 4'd4,
        KIND_ABS     = 4'd5,
        KIND_NEG     = 4'd6,
        KIND_FROMINT = 4'd7,
        KIND_TOINT   = 4'd8,
        KIND_ROUND   = 4'd9,
        KIND_RATIO   = 4'd10,
        KIND_COMPARE = 4'd11
    } kind_t;

    // Information that rides alongside the division.
    typedef struct packed {
        logic [63:0] divisor;
        logic        negate;
        logic [63:0] post_mult;
        logic        use_div;
        logic        div_zero;
        logic [63:0] direct;
        logic        lt;
        logic        eq;
        logic        gt;
    } side_t;

    typedef struct packed {
        logic [63:0]  rem;
        logic [127:0] work;
        side_t        side;
    } div_slot_t;

    typedef struct packed {
        logic [63:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        div_zero;
    } result_t;

endpackage

>>> rtl/fpda_front.sv
// ----------------------------------------------------------------------------
// fpda_front
// Operand preparation and the 64 x 64 wide product, three register stages.
// ----------------------------------------------------------------------------
module fpda_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [3:0]          kind,
    input  logic signed [63:0]  operand_a,
    input  logic signed [63:0]  operand_b,
    output logic                out_valid,
    output fpda_pkg::div_slot_t out_slot
);
    import fpda_pkg::*;

    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] x_next;
    logic [63:0] y_next;
    side_t       side_next;

    logic        v0_reg;
    logic [63:0] x_reg;
    logic [63:0] y_reg;
    side_t       side0_reg;

    logic        v1_reg;
    logic [63:0] pp0_reg;
    logic [63:0] pp1_reg;
    logic [63:0] pp2_reg;
    logic [63:0] pp3_reg;
    side_t       side1_reg;

    logic        v2_reg;
    logic [127:0] prod_reg;
    side_t       side2_reg;

    logic [127:0] prod_next;

    always_comb
    begin
        mag_a = operand_a[63] ? (64'd0 - operand_a) : operand_a;
        mag_b = operand_b[63] ? (64'd0 - operand_b) : operand_b;
        x_next = mag_a;
        y_next = 64'd1;
        side_next.divisor   = 64'd1;
        side_next.negate    = operand_a[63];
        side_next.post_mult = 64'd1;
        side_next.use_div   = 1'b0;
        side_next.div_zero  = 1'b0;
        side_next.direct    = 64'd0;
        side_next.lt        = operand_a < operand_b;
        side_next.eq        = operand_a == operand_b;
        side_next.gt        = operand_a > operand_b;
        case (kind_t'(kind))
            KIND_ADD:     side_next.direct = operand_a + operand_b;
            KIND_SUB:     side_next.direct = operand_a - operand_b;
            KIND_ABS:     side_next.direct = mag_a;
            KIND_NEG:     side_next.direct = 64'd0 - operand_a;
            KIND_MUL:
            begin
                y_next                = mag_b;
                side_next.divisor     = SCALE;
                side_next.negate      = operand_a[63] ^ operand_b[63];
                side_next.use_div     = 1'b1;
            end
            KIND_DIV:
            begin
                y_next                = SCALE;
                side_next.divisor     = mag_b;
                side_next.negate      = operand_a[63] ^ operand_b[63];
                side_next.use_div     = 1'b1;
                side_next.div_zero    = operand_b == 64'sd0;
            end
            KIND_INTDIV:
            begin
                side_next.divisor     = mag_b;
                side_next.negate      = operand_a[63] ^ operand_b[63];
                side_next.use_div     = 1'b1;
                side_next.div_zero    = operand_b == 64'sd0;
            end
            KIND_FROMINT:
            begin
                y_next                = SCALE;
                side_next.use_div     = 1'b1;
            end
            KIND_TOINT:
            begin
                side_next.divisor     = SCALE;
                side_next.use_div     = 1'b1;
            end
            KIND_ROUND:
            begin
                // The magnitude plus half a unit stays below 2^64.
                x_next                = mag_a + SCALE_HALF;
                side_next.divisor     = SCALE;
                side_next.use_div     = 1'b1;
            end
            KIND_RATIO:
            begin
                x_next                = SCALE;
                side_next.divisor     = mag_b;
                side_next.post_mult   = mag_a;
                side_next.negate      = operand_a[63] ^ operand_b[63];
                side_next.use_div     = 1'b1;
                side_next.div_zero    = operand_b == 64'sd0;
            end
            default:      side_next.direct = 64'd0;
        endcase
    end

    assign prod_next = {64'd0, pp0_reg}
                     + {32'd0, pp1_reg, 32'd0}
                     + {32'd0, pp2_reg, 32'd0}
                     + {pp3_reg, 64'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            side0_reg <= side_next;
            pp0_reg   <= x_reg[31:0]  * y_reg[31:0];
            pp1_reg   <= x_reg[31:0]  * y_reg[63:32];
            pp2_reg   <= x_reg[63:32] * y_reg[31:0];
            pp3_reg   <= x_reg[63:32] * y_reg[63:32];
            side1_reg <= side0_reg;
            prod_reg  <= prod_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid     = v2_reg;
    assign out_slot.rem  = 64'd0;
    assign out_slot.work = prod_reg;
    assign out_slot.side = side2_reg;

endmodule

>>> rtl/fpda_div_cell.sv
// ----------------------------------------------------------------------------
// fpda_div_cell
// One restoring division step: shifts in a dividend bit, produces a quotient bit.
// ----------------------------------------------------------------------------
module fpda_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  fpda_pkg::div_slot_t in_slot,
    output logic                out_valid,
    output fpda_pkg::div_slot_t out_slot
);
    import fpda_pkg::*;

    logic [64:0] trial;
    logic        fits;
    div_slot_t   slot_next;
    logic        valid_reg;
    div_slot_t   slot_reg;

    always_comb
    begin
        trial = {in_slot.rem, in_slot.work[127]};
        fits  = trial >= {1'b0, in_slot.side.divisor};
        slot_next      = in_slot;
        slot_next.rem  = fits ? 64'(trial - {1'b0, in_slot.side.divisor}) : trial[63:0];
        slot_next.work = {in_slot.work[126:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slot_reg <= slot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_slot  = slot_reg;

endmodule

>>> rtl/fpda_back.sv
// ----------------------------------------------------------------------------
// fpda_back
// Ratio post-multiply, sign fix-up and result selection, two register stages.
// ----------------------------------------------------------------------------
module fpda_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  fpda_pkg::div_slot_t in_slot,
    output logic                out_valid,
    output fpda_pkg::result_t   out_res
);
    import fpda_pkg::*;

    logic        v0_reg;
    logic [63:0] pp0_reg;
    logic [63:0] pp1_reg;
    logic [63:0] pp2_reg;
    side_t       side_reg;
    logic        v1_reg;
    result_t     res_reg;

    logic [63:0] low_prod;
    logic [63:0] signed_q;
    logic [63:0] mid_sum;
    result_t     res_next;

    always_comb
    begin
        // Only the low 64 bits of the product are kept.
        mid_sum  = pp1_reg + pp2_reg;
        low_prod = pp0_reg + {mid_sum[31:0], 32'd0};
        signed_q = side_reg.negate ? (64'd0 - low_prod) : low_prod;
        res_next.lt       = side_reg.lt;
        res_next.eq       = side_reg.eq;
        res_next.gt       = side_reg.gt;
        res_next.div_zero = side_reg.div_zero;
        if (side_reg.div_zero)
        begin
            res_next.value = 64'd0;
        end
        else if (side_reg.use_div)
        begin
            res_next.value = signed_q;
        end
        else
        begin
            res_next.value = side_reg.direct;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp0_reg  <= in_slot.work[31:0]  * in_slot.side.post_mult[31:0];
            pp1_reg  <= in_slot.work[31:0]  * in_slot.side.post_mult[63:32];
            pp2_reg  <= in_slot.work[63:32] * in_slot.side.post_mult[31:0];
            side_reg <= in_slot.side;
            res_reg  <= res_next;
        end
    end

    assign out_valid = v1_reg;
    assign out_res   = res_reg;

endmodule

>>> rtl/fixed_point_decimal_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_alu_core
// Pipelined ALU for signed 64-bit prices scaled by a fixed decimal factor.
// ----------------------------------------------------------------------------
// Each input transfer carries an operation code (kind) and two signed 64-bit
// operands; each one produces exactly one output transfer holding the result
// value and the signed less, equal and greater flags of operand_a against
// operand_b, plus a divide-by-zero flag.
// Both channels use valid and stall. A transfer happens on a rising edge at
// which valid is high and stall is low.
// One operation is accepted every clock cycle while in_stall is low. Each one
// passes through operand preparation and the 64 x 64 product, 128 cells of
// restoring division (one quotient bit per cell), post-multiply and sign
// correction, and the output register.
// Every operation, including the simple ones, takes the same path, so results
// leave in input order.
// When the receiver stalls, the output register holds its result and a skid
// register catches the next one; once the skid register is full the whole
// pipeline freezes and in_stall is raised until the output drains.
// Reset clears every valid bit; no result is presented after reset.
module fixed_point_decimal_alu_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         kind,
    input  logic signed [63:0] operand_a,
    input  logic signed [63:0] operand_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] value,
    output logic               is_less,
    output logic               is_equal,
    output logic               is_greater,
    output logic               divide_by_zero
);
    import fpda_pkg::*;

    logic      en;
    logic      chain_valid [DIV_STEPS+1];
    div_slot_t chain_slot  [DIV_STEPS+1];
    logic      pipe_valid;
    result_t   pipe_res;

    logic      out_valid_reg;
    result_t   out_res_reg;
    logic      skid_valid_reg;
    result_t   skid_res_reg;
    logic      out_free;

    // The pipeline advances as long as the skid register is empty.
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    fpda_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (chain_valid[0]),
        .out_slot  (chain_slot[0])
    );

    // The division chain: each cell settles one quotient bit and passes the
    // partial remainder on to its neighbour.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        fpda_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_slot   (chain_slot[i]),
            .out_valid (chain_valid[i+1]),
            .out_slot  (chain_slot[i+1])
        );
    end

    fpda_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[DIV_STEPS]),
        .in_slot   (chain_slot[DIV_STEPS]),
        .out_valid (pipe_valid),
        .out_res   (pipe_res)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (pipe_valid)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (pipe_valid)
        begin
            if (out_free)
            begin
                out_res_reg <= pipe_res;
            end
            else
            begin
                skid_res_reg <= pipe_res;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = out_res_reg.value;
    assign is_less        = out_res_reg.lt;
    assign is_equal       = out_res_reg.eq;
    assign is_greater     = out_res_reg.gt;
    assign divide_by_zero = out_res_reg.div_zero;

endmodule

>>> rtl/fpda_checker.sv
// ----------------------------------------------------------------------------
// fpda_checker
// Port-level checks of the scaled decimal fixed-point ALU, bound to the top.
// ----------------------------------------------------------------------------
module fpda_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [63:0] value,
    input logic               is_less,
    input logic               is_equal,
    input logic               is_greater,
    input logic               divide_by_zero
);

    // A stalled result stays presented and its value unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("stalled result changed");

    // Exactly one ordering flag describes the two operands.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({is_less, is_equal, is_greater}))
        else $error("comparison flags not exclusive");

    // A zero divisor always yields a zero value.
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> value == 64'sd0)
        else $error("divide by zero with non-zero value");

endmodule

bind fixed_point_decimal_alu_core fpda_checker u_fpda_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .value          (value),
    .is_less        (is_less),
    .is_equal       (is_equal),
    .is_greater     (is_greater),
    .divide_by_zero (divide_by_zero)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the scaled decimal fixed-point ALU core.
// ----------------------------------------------------------------------------
// Operations are driven through the valid/stall input channel, each accepted
// transfer is predicted at once and queued, and every output transfer is
// compared field by field with the oldest queued prediction. Several idling
// phases put gaps and stalls on every stage of the pipeline.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpda_pkg::*;

    // Predicted result of one operation, in the same shape as the outputs.
    typedef struct {
        logic [63:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
    } alu_result_t;

    // Scoreboard: holds predictions in input order and checks results.
    class alu_scoreboard;
        alu_result_t pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        static function logic [63:0] mag(logic [63:0] x);
            return x[63] ? -x : x;
        endfunction

        // Signed (x * y) / d truncated toward zero, low 64 bits kept.
        static function logic [63:0] scaled(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] dmag, logic dneg);
            logic [127:0] prod;
            logic [127:0] quo;
            logic         neg;
            neg  = x[63] ^ y[63] ^ dneg;
            prod = {64'd0, mag(x)} * {64'd0, mag(y)};
            quo  = prod / {64'd0, dmag};
            return neg ? -quo[63:0] : quo[63:0];
        endfunction

        function alu_result_t predict(logic [3:0] op, logic [63:0] a, logic [63:0] b);
            alu_result_t r;
            logic [63:0] q;
            r.value = '0;
            r.dz    = 1'b0;
            r.lt    = $signed(a) < $signed(b);
            r.eq    = a == b;
            r.gt    = $signed(a) > $signed(b);
            case (op)
                KIND_ADD:     r.value = a + b;
                KIND_SUB:     r.value = a - b;
                KIND_MUL:     r.value = scaled(a, b, SCALE, 1'b0);
                KIND_DIV:
                    if (b == 0) r.dz = 1'b1;
                    else r.value = scaled(a, SCALE, mag(b), b[63]);
                KIND_INTDIV:
                    if (b == 0) r.dz = 1'b1;
                    else r.value = scaled(a, 64'd1, mag(b), b[63]);
                KIND_ABS:     r.value = mag(a);
                KIND_NEG:     r.value = -a;
                KIND_FROMINT: r.value = a * SCALE;
                KIND_TOINT:   r.value = scaled(a, 64'd1, SCALE, 1'b0);
                KIND_ROUND:
                begin
                    // Wide sum, so the rounding never wraps near the limits.
                    q = 64'(({1'b0, mag(a)} + {1'b0, SCALE >> 1}) / {1'b0, SCALE});
                    r.value = a[63] ? -q : q;
                end
                KIND_RATIO:
                    if (b == 0) r.dz = 1'b1;
                    else
                    begin
                        q = SCALE / mag(b);
                        if (b[63]) q = -q;
                        r.value = q * a;
                    end
                default:      r.value = '0;
            endcase
            return r;
        endfunction

        function void note_operation(logic [3:0] op, logic [63:0] a, logic [63:0] b);
            pending.push_back(predict(op, a, b));
        endfunction

        task automatic report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task automatic check_result(logic [63:0] v, logic lt, logic eq, logic gt,
                                    logic dz);
            alu_result_t e;
            if (pending.size() == 0)
            begin
                report("result with no operation outstanding");
                return;
            end
            e = pending.pop_front();
            if (v !== e.value)
                report($sformatf("value %h, expected %h", v, e.value));
            if (lt !== e.lt) report($sformatf("is_less %b, expected %b", lt, e.lt));
            if (eq !== e.eq) report($sformatf("is_equal %b, expected %b", eq, e.eq));
            if (gt !== e.gt) report($sformatf("is_greater %b, expected %b", gt, e.gt));
            if (dz !== e.dz)
                report($sformatf("divide_by_zero %b, expected %b", dz, e.dz));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [3:0]         kind = '0;
    logic signed [63:0] operand_a = '0;
    logic signed [63:0] operand_b = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [63:0] value;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               divide_by_zero;

    // Idle percentages for the sender and the receiver in the current phase.
    int          send_idle = 0;
    int          recv_stall = 0;
    alu_scoreboard board = new();

    always #5 clk = ~clk;

    fixed_point_decimal_alu_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .is_less        (is_less),
        .is_equal       (is_equal),
        .is_greater     (is_greater),
        .divide_by_zero (divide_by_zero)
    );

    // The receiver stalls at random, and every output transfer is checked
    // against the oldest prediction at the edge where it happens.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(value, is_less, is_equal, is_greater, divide_by_zero);
            out_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    // Presents one operation, with an optional random gap first, and holds it
    // until the block takes it. The prediction is queued at that same edge.
    task automatic send_operation(logic [3:0] op, logic [63:0] a, logic [63:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= op;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (in_stall);
        board.note_operation(op, a, b);
    endtask

    // Operands chosen to reach the extremes, small values, plain prices and random values.
    function automatic logic [63:0] pick_operand();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return 64'h8000_0000_0000_0000;
            1:       return 64'h7FFF_FFFF_FFFF_FFFF;
            2:       return 64'(int'($urandom_range(6)) - 3);
            3:       return SCALE * 64'($urandom_range(4)) * ($urandom_range(1) ? 64'd1 : -64'd1);
            4, 5:    return 64'($signed(r[39:0]));
            6:       return 64'($signed(r[31:0]));
            default: return r;
        endcase
    endfunction

    task automatic run_random(int count);
        logic [63:0] a;
        logic [63:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = pick_operand();
            // Equal operands now and then, so the equal flag is exercised.
            b = ($urandom_range(9) == 0) ? a : pick_operand();
            send_operation(4'($urandom_range(15)), a, b);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every operation, the extremes, zero divisors,
        // wrapping of abs, neg and intdiv, rounding at the half and two of
        // the unused operation codes.
        send_operation(KIND_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
        send_operation(KIND_SUB, 64'h8000_0000_0000_0000, 64'd1);
        send_operation(KIND_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_operation(KIND_MUL, -64'sd1500000000, 64'd2500000000);
        send_operation(KIND_DIV, 64'd7000000000, -64'sd3000000000);
        send_operation(KIND_DIV, 64'd5, 64'd0);
        send_operation(KIND_INTDIV, 64'h8000_0000_0000_0000, -64'sd1);
        send_operation(KIND_INTDIV, -64'sd7, 64'd2);
        send_operation(KIND_INTDIV, 64'd1, 64'd0);
        send_operation(KIND_ABS, 64'h8000_0000_0000_0000, 64'd0);
        send_operation(KIND_ABS, -64'sd42, 64'h7FFF_FFFF_FFFF_FFFF);
        send_operation(KIND_NEG, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_operation(KIND_FROMINT, 64'h7FFF_FFFF_FFFF_FFFF, 64'd3);
        send_operation(KIND_TOINT, -64'sd2999999999, 64'd0);
        send_operation(KIND_ROUND, 64'd1500000000, 64'd0);
        send_operation(KIND_ROUND, -64'sd2500000000, 64'd0);
        send_operation(KIND_ROUND, 64'd1499999999, 64'd0);
        send_operation(KIND_ROUND, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
        send_operation(KIND_ROUND, 64'h8000_0000_0000_0000, 64'd0);
        send_operation(KIND_RATIO, 64'd3, -64'sd4);
        send_operation(KIND_RATIO, 64'd3, 64'd0);
        send_operation(KIND_RATIO, -64'sd5, 64'h8000_0000_0000_0000);
        send_operation(KIND_COMPARE, -64'sd1, 64'd1);
        send_operation(4'd12, 64'd9, 64'd9);
        send_operation(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);

        // Random part over the idling phases, the last with no idling again.
        run_random(300);
        send_idle = 88;
        run_random(250);
        send_idle = 0;
        recv_stall = 88;
        run_random(250);
        send_idle = 16;
        recv_stall = 16;
        run_random(250);
        send_idle = 0;
        recv_stall = 0;
        run_random(150);
        in_valid <= 1'b0;

        // Drain, then keep watching the quiet outputs for strays.
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("fixed_point_decimal_alu_core regression: pass");
        else
            $display("fixed_point_decimal_alu_core regression: fail");
        $finish;
    end

    // Watchdog, generous against the slowest phase with heavy stalling.
    initial
    begin
        #20ms;
        $display("fixed_point_decimal_alu_core regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/fpda_pkg.sv
rtl/fpda_front.sv
rtl/fpda_div_cell.sv
rtl/fpda_back.sv
rtl/fixed_point_decimal_alu_core.sv
rtl/fpda_checker.sv
tb/testbench.sv
